FILE: rtl/assert_macros.svh
// Assertion macros used by the ring buffer engine datapath (urb_datapath).
// Expects clk and rst to be in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset.
`define URB_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define URB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/urb_pkg.sv
// Shared types and constants for the UART ring buffer engine.
// No dependencies.
`timescale 1ns / 1ps

package urb_pkg;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 5;

  localparam int DEF_RX_DEPTH = 16;
  localparam int DEF_TX_DEPTH = 16;

  localparam logic [FUNC_W-1:0] FN_RX     = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TXDONE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PUT    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_GET    = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
  } urb_cmd_t;

endpackage

FILE: rtl/urb_ctrl.sv
// Sequencer for the ring buffer engine: accept, execute, deliver.
// Depends on urb_pkg.
`timescale 1ns / 1ps

module urb_ctrl
  import urb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output urb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_RESP;
      S_RESP: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready    = (state == S_IDLE) && !rst;
  assign out_valid   = (state == S_RESP);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC);

endmodule

FILE: rtl/urb_datapath.sv
// Ring pointers, counts, busy flag, both byte stores and the result register.
// Depends on urb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module urb_datapath
  import urb_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  urb_cmd_t           cmd,
  input  logic [FUNC_W-1:0]  func,
  input  logic [BYTE_W-1:0]  data_byte,
  output logic               tx_start,
  output logic [BYTE_W-1:0]  tx_byte,
  output logic               rx_valid,
  output logic [BYTE_W-1:0]  rx_byte,
  output logic               rx_dropped,
  output logic               put_refused,
  output logic [LEVEL_W-1:0] tx_room,
  output logic [LEVEL_W-1:0] rx_level,
  output logic               tx_busy
);

  localparam int RAW = $clog2(RX_DEPTH);
  localparam int TAW = $clog2(TX_DEPTH);
  localparam int RCW = $clog2(RX_DEPTH + 1);
  localparam int TCW = $clog2(TX_DEPTH + 1);
  localparam int ROW = (RCW > LEVEL_W) ? RCW : LEVEL_W;
  localparam int TOW = (TCW > LEVEL_W) ? TCW : LEVEL_W;

  localparam logic [RCW:0]   RX_FULL  = (RCW + 1)'(RX_DEPTH);
  localparam logic [TCW:0]   TX_FULL  = (TCW + 1)'(TX_DEPTH);
  localparam logic [RAW-1:0] RX_LAST  = RAW'(RX_DEPTH - 1);
  localparam logic [TAW-1:0] TX_LAST  = TAW'(TX_DEPTH - 1);

  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

  logic [FUNC_W-1:0] func_r;
  logic [BYTE_W-1:0] byte_r;
  logic [RAW-1:0]    rx_head;
  logic [RCW-1:0]    rx_count;
  logic [TAW-1:0]    tx_head;
  logic [TCW-1:0]    tx_count;
  logic              busy;

  logic              tx_start_r;
  logic              tx_from_mem;
  logic              rx_valid_r;
  logic              rx_dropped_r;
  logic              put_refused_r;
  logic [BYTE_W-1:0] rx_rd;
  logic [BYTE_W-1:0] tx_rd;

  logic              rx_full;
  logic              tx_full;
  logic              rx_wr;
  logic              rx_pop;
  logic              tx_pop;
  logic              tx_queue;
  logic              tx_direct;
  logic [RCW:0]      rx_sum;
  logic [TCW:0]      tx_sum;
  logic [RCW:0]      rx_wsum;
  logic [TCW:0]      tx_wsum;
  logic [RAW-1:0]    rx_waddr;
  logic [TAW-1:0]    tx_waddr;
  logic [RAW-1:0]    rx_head_inc;
  logic [TAW-1:0]    tx_head_inc;
  logic [TCW-1:0]    room_full;
  logic [ROW-1:0]    rx_level_ext;
  logic [TOW-1:0]    tx_room_ext;

  assign rx_full   = ({1'b0, rx_count} >= RX_FULL);
  assign tx_full   = ({1'b0, tx_count} >= TX_FULL);
  assign rx_wr     = cmd.exec && (func_r == FN_RX) && !rx_full;
  assign rx_pop    = cmd.exec && (func_r == FN_GET) && (rx_count != '0);
  assign tx_pop    = cmd.exec && (func_r == FN_TXDONE) && (tx_count != '0);
  assign tx_queue  = cmd.exec && (func_r == FN_PUT) && !tx_full && busy;
  assign tx_direct = cmd.exec && (func_r == FN_PUT) && !tx_full && !busy;

  // write slot: (head + count) mod depth, sum stays below twice the depth
  assign rx_sum   = (RCW + 1)'(rx_head) + (RCW + 1)'(rx_count);
  assign tx_sum   = (TCW + 1)'(tx_head) + (TCW + 1)'(tx_count);
  assign rx_wsum  = (rx_sum >= RX_FULL) ? (rx_sum - RX_FULL) : rx_sum;
  assign tx_wsum  = (tx_sum >= TX_FULL) ? (tx_sum - TX_FULL) : tx_sum;
  assign rx_waddr = rx_wsum[RAW-1:0];
  assign tx_waddr = tx_wsum[TAW-1:0];

  assign rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
  assign tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func;
      byte_r <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head  <= '0;
      rx_count <= '0;
      tx_head  <= '0;
      tx_count <= '0;
      busy     <= 1'b0;
    end else if (cmd.exec) begin
      if (rx_wr) begin
        rx_count <= rx_count + 1'b1;
      end
      if (rx_pop) begin
        rx_count <= rx_count - 1'b1;
        rx_head  <= rx_head_inc;
      end
      if (func_r == FN_TXDONE) begin
        busy <= tx_pop;
      end
      if (tx_pop) begin
        tx_count <= tx_count - 1'b1;
        tx_head  <= tx_head_inc;
      end
      if (tx_queue) begin
        tx_count <= tx_count + 1'b1;
      end
      if (tx_direct) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      tx_start_r    <= tx_pop || tx_direct;
      tx_from_mem   <= tx_pop;
      rx_valid_r    <= rx_pop;
      rx_dropped_r  <= (func_r == FN_RX) && rx_full;
      put_refused_r <= (func_r == FN_PUT) && tx_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_wr) begin
      rx_mem[rx_waddr] <= byte_r;
    end
    if (rx_pop) begin
      rx_rd <= rx_mem[rx_head];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_queue) begin
      tx_mem[tx_waddr] <= byte_r;
    end
    if (tx_pop) begin
      tx_rd <= tx_mem[tx_head];
    end
  end

  assign room_full    = TCW'(TX_DEPTH) - tx_count;
  assign tx_room_ext  = TOW'(room_full);
  assign rx_level_ext = ROW'(rx_count);

  assign tx_start    = tx_start_r;
  assign tx_byte     = !tx_start_r ? '0 : (tx_from_mem ? tx_rd : byte_r);
  assign rx_valid    = rx_valid_r;
  assign rx_byte     = rx_valid_r ? rx_rd : '0;
  assign rx_dropped  = rx_dropped_r;
  assign put_refused = put_refused_r;
  assign tx_room     = tx_room_ext[LEVEL_W-1:0];
  assign rx_level    = rx_level_ext[LEVEL_W-1:0];
  assign tx_busy     = busy;

  `URB_ASSERT(a_rx_count_bound, {1'b0, rx_count} <= RX_FULL)
  `URB_ASSERT(a_tx_queue_busy, (tx_count == '0) || busy)
  `URB_ASSERT_NEXT(a_rx_pop_count, rx_pop, rx_count == $past(rx_count) - 1'b1)
  `URB_ASSERT_NEXT(a_tx_start_src, cmd.exec, !(tx_start_r && rx_valid_r))

endmodule

FILE: rtl/uart_ring_buffer_engine.sv
// Top level of the UART ring buffer engine: sequencer plus datapath.
// Depends on urb_pkg, urb_ctrl and urb_datapath.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | func, data_byte
//   out     | out_valid / out_ready| tx_start, tx_byte, rx_valid, rx_byte, rx_dropped,
//           |                      | put_refused, tx_room, rx_level, tx_busy
//
// One request passes through three steps: accept, execute (one store access), deliver.
// The next request is accepted in the cycle after its result is taken.
// A stall on out holds the result and keeps in_ready low.
// Synchronous reset clears pointers, counts and the busy flag; stores need no clear.
`timescale 1ns / 1ps

module uart_ring_buffer_engine
  import urb_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  func,
  input  logic [BYTE_W-1:0]  data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               tx_start,
  output logic [BYTE_W-1:0]  tx_byte,
  output logic               rx_valid,
  output logic [BYTE_W-1:0]  rx_byte,
  output logic               rx_dropped,
  output logic               put_refused,
  output logic [LEVEL_W-1:0] tx_room,
  output logic [LEVEL_W-1:0] rx_level,
  output logic               tx_busy
);

  urb_cmd_t cmd;

  urb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  urb_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .data_byte   (data_byte),
    .tx_start    (tx_start),
    .tx_byte     (tx_byte),
    .rx_valid    (rx_valid),
    .rx_byte     (rx_byte),
    .rx_dropped  (rx_dropped),
    .put_refused (put_refused),
    .tx_room     (tx_room),
    .rx_level    (rx_level),
    .tx_busy     (tx_busy)
  );

endmodule
